### rtl/cdct_pkg.sv
// shared constants, widths and types for the corner disc coverage texel unit
// no dependencies; imported by every module of the block
`default_nettype none

package cdct_pkg;

    // block geometry
    localparam int unsigned MIN_RADIUS = 3;
    localparam int unsigned MAX_RADIUS = 26;
    localparam int unsigned SUBSAMPLES = 16;

    // port widths
    localparam int unsigned IW     = 5;   // radius, col, row, atlas_y
    localparam int unsigned XW     = 9;   // atlas_x
    localparam int unsigned ALPHAW = 8;   // alpha

    // fixed point in units of 1/(2*SUBSAMPLES) texel
    localparam int unsigned S2    = 2 * SUBSAMPLES;
    localparam int unsigned LW    = $clog2(S2 * (1 << IW));  // unsigned scaled radius
    localparam int unsigned DW    = LW + 1;                   // signed subsample offset
    localparam int unsigned QW    = 2 * LW;                   // squared distance
    localparam int unsigned TW    = QW + 1;                   // signed threshold
    localparam int unsigned BW    = XW + 1;                   // block start arithmetic

    // hit counting
    localparam int unsigned TOTAL = SUBSAMPLES * SUBSAMPLES;
    localparam int unsigned CW    = $clog2(SUBSAMPLES + 1);   // hits in one row
    localparam int unsigned GRP   = 4;                        // rows per partial sum
    localparam int unsigned NGRP  = (SUBSAMPLES + GRP - 1) / GRP;
    localparam int unsigned GW    = $clog2(GRP * SUBSAMPLES + 1);
    localparam int unsigned HW    = $clog2(TOTAL + 1);
    localparam int unsigned MW    = HW + ALPHAW;              // hits * 255 plus rounding

    // pipeline depth
    localparam int unsigned NSTG  = 8;

    typedef logic signed [DW-1:0] t_delta;
    typedef logic [LW-1:0]        t_lim;
    typedef logic [QW-1:0]        t_sq;
    typedef logic signed [TW-1:0] t_thr;
    typedef logic [CW-1:0]        t_cnt;
    typedef logic [GW-1:0]        t_grp;
    typedef logic [HW-1:0]        t_hits;

    // per beat side data that rides along with the coverage math
    typedef struct packed {
        logic          in_range;
        logic [XW-1:0] atlas_x;
        logic [IW-1:0] atlas_y;
    } t_side;

endpackage

`default_nettype wire

### rtl/corner_disc_coverage_texel_unit.sv
// top level of the corner disc coverage texel unit: pipeline valid and stall control
// depends on cdct_pkg, cdct_front, cdct_square, cdct_hits, cdct_sum
`default_nettype none

// one beat in carries a corner radius and a texel column and row inside that
// radius's block; one beat out carries the texel's coverage alpha (rounded
// share of 16x16 subsamples inside the disc centred on the block's inner
// corner), its packed atlas column and row, and an in-range flag
// out-of-range beats come out with in_range low and all other fields zero
//
// both channels use valid/stall: a beat moves at a clock edge with valid high
// and stall low
// an input beat reaches the output valid through the eight
// register stages (offsets, squares, thresholds, compares, row counts,
// partial sums, total, alpha)
// throughput: one beat per clock unless the receiver stalls; every stage holds
// a valid bit and loads whenever it is empty or its successor moves, so bubbles close up
// when the receiver stalls, the output beat holds and the stages behind it
// keep filling; o_stall rises only once all eight stages hold beats
// reset clears all valid bits; the datapath registers are not reset

module corner_disc_coverage_texel_unit
    import cdct_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [IW-1:0]     i_radius,
    input  wire logic [IW-1:0]     i_col,
    input  wire logic [IW-1:0]     i_row,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [ALPHAW-1:0]      o_alpha,
    output logic [XW-1:0]          o_atlas_x,
    output logic [IW-1:0]          o_atlas_y,
    output logic                   o_in_range
);

    // stage k (0 based) loads when w_adv[k]
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_adv;

    t_delta w_dx [SUBSAMPLES];
    t_delta w_dy [SUBSAMPLES];
    t_lim   w_lim;
    t_side  w_side1;
    t_sq    w_dx2 [SUBSAMPLES];
    t_thr   w_thr [SUBSAMPLES];
    t_side  w_side3;
    t_cnt   w_cnt [SUBSAMPLES];
    t_side  w_side5;
    t_side  w_side8;

    // a stage may load if it is empty or its contents move on this edge
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = int'(NSTG) - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld = r_vld;
        if (w_adv[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < int'(NSTG); k++) begin
            if (w_adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[NSTG-1];

    // offsets of every subsample column and row from the disc centre
    cdct_front u_front (
        .i_clk    (i_clk),
        .i_en     (w_adv[0]),
        .i_radius (i_radius),
        .i_col    (i_col),
        .i_row    (i_row),
        .o_dx     (w_dx),
        .o_dy     (w_dy),
        .o_lim    (w_lim),
        .o_side   (w_side1)
    );

    // squares, then radius squared minus row term
    cdct_square u_square (
        .i_clk    (i_clk),
        .i_en_sq  (w_adv[1]),
        .i_en_thr (w_adv[2]),
        .i_dx     (w_dx),
        .i_dy     (w_dy),
        .i_lim    (w_lim),
        .i_side   (w_side1),
        .o_dx2    (w_dx2),
        .o_thr    (w_thr),
        .o_side   (w_side3)
    );

    // 16x16 compare array, then popcount per row
    cdct_hits u_hits (
        .i_clk    (i_clk),
        .i_en_cmp (w_adv[3]),
        .i_en_cnt (w_adv[4]),
        .i_dx2    (w_dx2),
        .i_thr    (w_thr),
        .i_side   (w_side3),
        .o_cnt    (w_cnt),
        .o_side   (w_side5)
    );

    // two level adder tree and alpha scaling into the output register
    cdct_sum u_sum (
        .i_clk    (i_clk),
        .i_en_grp (w_adv[5]),
        .i_en_tot (w_adv[6]),
        .i_en_out (w_adv[7]),
        .i_cnt    (w_cnt),
        .i_side   (w_side5),
        .o_alpha  (o_alpha),
        .o_side   (w_side8)
    );

    assign o_atlas_x  = w_side8.atlas_x;
    assign o_atlas_y  = w_side8.atlas_y;
    assign o_in_range = w_side8.in_range;

endmodule

`default_nettype wire

### rtl/cdct_front.sv
// stage 1: range check, atlas placement and subsample offsets per column and row
// depends on cdct_pkg
`default_nettype none

module cdct_front
    import cdct_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [IW-1:0] i_radius,
    input  wire logic [IW-1:0] i_col,
    input  wire logic [IW-1:0] i_row,
    output t_delta             o_dx [SUBSAMPLES],
    output t_delta             o_dy [SUBSAMPLES],
    output t_lim               o_lim,
    output t_side              o_side
);

    t_delta          w_dx [SUBSAMPLES];
    t_delta          w_dy [SUBSAMPLES];
    t_lim            w_lim;
    logic [BW-1:0]   w_prod;
    logic [BW-1:0]   w_start;
    logic            w_ok;
    t_side           w_side;

    t_delta          r_dx [SUBSAMPLES];
    t_delta          r_dy [SUBSAMPLES];
    t_lim            r_lim;
    t_side           r_side;

    always_comb begin
        w_lim = t_lim'(LW'(i_radius) * LW'(S2));
        for (int k = 0; k < int'(SUBSAMPLES); k++) begin
            w_dx[k] = t_delta'(DW'(i_col) * DW'(S2) + DW'(2 * k + 1) - DW'(w_lim));
            w_dy[k] = t_delta'(DW'(i_row) * DW'(S2) + DW'(2 * k + 1) - DW'(w_lim));
        end

        // block start = sum of smaller radii plus one gutter each
        w_prod  = BW'(BW'(i_radius) - BW'(1)) * BW'(i_radius);
        w_start = ((w_prod - BW'((MIN_RADIUS - 1) * MIN_RADIUS)) >> 1)
                  + BW'(i_radius) - BW'(MIN_RADIUS) + BW'(i_col);

        w_ok = (i_radius >= IW'(MIN_RADIUS)) && (i_radius <= IW'(MAX_RADIUS))
               && (i_col < i_radius) && (i_row < i_radius);

        w_side.in_range = w_ok;
        w_side.atlas_x  = w_ok ? w_start[XW-1:0] : '0;
        w_side.atlas_y  = w_ok ? i_row : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= w_dx;
            r_dy   <= w_dy;
            r_lim  <= w_lim;
            r_side <= w_side;
        end
    end

    assign o_dx   = r_dx;
    assign o_dy   = r_dy;
    assign o_lim  = r_lim;
    assign o_side = r_side;

endmodule

`default_nettype wire

### rtl/cdct_square.sv
// stages 2 and 3: squared offsets, squared radius and per row thresholds
// depends on cdct_pkg
`default_nettype none

module cdct_square
    import cdct_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_en_sq,
    input  wire logic   i_en_thr,
    input  wire t_delta i_dx [SUBSAMPLES],
    input  wire t_delta i_dy [SUBSAMPLES],
    input  wire t_lim   i_lim,
    input  wire t_side  i_side,
    output t_sq         o_dx2 [SUBSAMPLES],
    output t_thr        o_thr [SUBSAMPLES],
    output t_side       o_side
);

    logic signed [2*DW-1:0] w_px [SUBSAMPLES];
    logic signed [2*DW-1:0] w_py [SUBSAMPLES];
    t_sq                    w_lim2;
    t_thr                   w_thr [SUBSAMPLES];

    t_sq   r_dx2  [SUBSAMPLES];
    t_sq   r_dy2  [SUBSAMPLES];
    t_sq   r_lim2;
    t_side r_side2;
    t_sq   r_dx2b [SUBSAMPLES];
    t_thr  r_thr  [SUBSAMPLES];
    t_side r_side3;

    always_comb begin
        for (int k = 0; k < int'(SUBSAMPLES); k++) begin
            w_px[k] = i_dx[k] * i_dx[k];
            w_py[k] = i_dy[k] * i_dy[k];
        end
        w_lim2 = QW'(i_lim) * QW'(i_lim);
        // room left for the column term in each subsample row
        for (int j = 0; j < int'(SUBSAMPLES); j++) begin
            w_thr[j] = $signed({1'b0, r_lim2}) - $signed({1'b0, r_dy2[j]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sq) begin
            for (int k = 0; k < int'(SUBSAMPLES); k++) begin
                r_dx2[k] <= w_px[k][QW-1:0];
                r_dy2[k] <= w_py[k][QW-1:0];
            end
            r_lim2  <= w_lim2;
            r_side2 <= i_side;
        end
        if (i_en_thr) begin
            r_dx2b  <= r_dx2;
            r_thr   <= w_thr;
            r_side3 <= r_side2;
        end
    end

    assign o_dx2  = r_dx2b;
    assign o_thr  = r_thr;
    assign o_side = r_side3;

endmodule

`default_nettype wire

### rtl/cdct_hits.sv
// stages 4 and 5: subsample hit matrix and per row hit counts
// depends on cdct_pkg
`default_nettype none

module cdct_hits
    import cdct_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en_cmp,
    input  wire logic  i_en_cnt,
    input  wire t_sq   i_dx2 [SUBSAMPLES],
    input  wire t_thr  i_thr [SUBSAMPLES],
    input  wire t_side i_side,
    output t_cnt       o_cnt [SUBSAMPLES],
    output t_side      o_side
);

    logic [SUBSAMPLES-1:0] w_hit [SUBSAMPLES];

    logic [SUBSAMPLES-1:0] r_hit [SUBSAMPLES];
    t_side                 r_side4;
    t_cnt                  r_cnt [SUBSAMPLES];
    t_side                 r_side5;

    always_comb begin
        for (int j = 0; j < int'(SUBSAMPLES); j++) begin
            for (int k = 0; k < int'(SUBSAMPLES); k++) begin
                w_hit[j][k] = $signed({1'b0, i_dx2[k]}) <= i_thr[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_cmp) begin
            r_hit   <= w_hit;
            r_side4 <= i_side;
        end
        if (i_en_cnt) begin
            for (int j = 0; j < int'(SUBSAMPLES); j++) begin
                r_cnt[j] <= CW'($countones(r_hit[j]));
            end
            r_side5 <= r_side4;
        end
    end

    assign o_cnt  = r_cnt;
    assign o_side = r_side5;

endmodule

`default_nettype wire

### rtl/cdct_sum.sv
// stages 6 to 8: adder tree over row counts, alpha scaling and output register
// depends on cdct_pkg
`default_nettype none

module cdct_sum
    import cdct_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_en_grp,
    input  wire logic            i_en_tot,
    input  wire logic            i_en_out,
    input  wire t_cnt            i_cnt [SUBSAMPLES],
    input  wire t_side           i_side,
    output logic [ALPHAW-1:0]    o_alpha,
    output t_side                o_side
);

    t_grp            w_grp [NGRP];
    t_hits           w_tot;
    logic [MW-1:0]   w_scaled;

    t_grp            r_grp [NGRP];
    t_side           r_side6;
    t_hits           r_hits;
    t_side           r_side7;
    logic [ALPHAW-1:0] r_alpha;
    t_side           r_side8;

    always_comb begin
        for (int g = 0; g < int'(NGRP); g++) begin
            w_grp[g] = '0;
            for (int i = 0; i < int'(GRP); i++) begin
                if (g * int'(GRP) + i < int'(SUBSAMPLES)) begin
                    w_grp[g] = w_grp[g] + GW'(i_cnt[g * int'(GRP) + i]);
                end
            end
        end
        w_tot = '0;
        for (int g = 0; g < int'(NGRP); g++) begin
            w_tot = w_tot + HW'(r_grp[g]);
        end
        // rounded hits * 255 / total
        w_scaled = (MW'(r_hits) * MW'(255) + MW'(TOTAL / 2)) / MW'(TOTAL);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_grp) begin
            r_grp   <= w_grp;
            r_side6 <= i_side;
        end
        if (i_en_tot) begin
            r_hits  <= w_tot;
            r_side7 <= r_side6;
        end
        if (i_en_out) begin
            r_alpha <= r_side7.in_range ? w_scaled[ALPHAW-1:0] : '0;
            r_side8 <= r_side7;
        end
    end

    assign o_alpha = r_alpha;
    assign o_side  = r_side8;

endmodule

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for the corner disc coverage texel unit
// depends on cdct_pkg and corner_disc_coverage_texel_unit; predicts every beat in plain integers
`timescale 1ns / 100ps

module testbench;
    import cdct_pkg::*;

    // one predicted output beat
    typedef struct packed {
        logic [ALPHAW-1:0] alpha;
        logic [XW-1:0]     atlas_x;
        logic [IW-1:0]     atlas_y;
        logic              in_range;
    } t_texel_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [IW-1:0]     i_radius;
    logic [IW-1:0]     i_col;
    logic [IW-1:0]     i_row;
    logic              o_valid;
    logic              i_stall;
    logic [ALPHAW-1:0] o_alpha;
    logic [XW-1:0]     o_atlas_x;
    logic [IW-1:0]     o_atlas_y;
    logic              o_in_range;

    // predicted beats in input order, oldest first
    t_texel_result pending_texels[$];
    int            mismatch_count;

    // idle switches: when low, that side never inserts wait cycles
    bit sender_gaps_on;
    bit receiver_stalls_on;

    corner_disc_coverage_texel_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_radius   (i_radius),
        .i_col      (i_col),
        .i_row      (i_row),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_alpha    (o_alpha),
        .o_atlas_x  (o_atlas_x),
        .o_atlas_y  (o_atlas_y),
        .o_in_range (o_in_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("testbench failed");
        $finish;
    end

    // subsample coverage of one texel, exact integer disc test in 1/(2S) texel units
    function automatic t_texel_result coverage_texel(logic [IW-1:0] r, logic [IW-1:0] c,
                                                     logic [IW-1:0] w);
        t_texel_result res;
        int            ri, ci, wi, s2, lim, dx, dy, hits;
        int unsigned   x0;
        res = '0;
        ri  = r;
        ci  = c;
        wi  = w;
        if (ri >= int'(MIN_RADIUS) && ri <= int'(MAX_RADIUS) && ci < ri && wi < ri) begin
            s2   = 2 * int'(SUBSAMPLES);
            lim  = s2 * ri;
            hits = 0;
            for (int sy = 0; sy < int'(SUBSAMPLES); sy++) begin
                dy = s2 * wi + 2 * sy + 1 - lim;
                for (int sx = 0; sx < int'(SUBSAMPLES); sx++) begin
                    dx = s2 * ci + 2 * sx + 1 - lim;
                    if (dx * dx + dy * dy <= lim * lim)
                        hits++;
                end
            end
            res.alpha = ALPHAW'((hits * 255 + int'(TOTAL) / 2) / int'(TOTAL));
            // block start: all smaller radii plus a one-texel gutter each
            x0 = ((ri - 1) * ri - (int'(MIN_RADIUS) - 1) * int'(MIN_RADIUS)) / 2
                 + (ri - int'(MIN_RADIUS));
            res.atlas_x  = XW'(x0 + ci);   // wraps at the port width
            res.atlas_y  = w;
            res.in_range = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // send one beat: optional idle gap, then hold valid until the block takes it
    task automatic send_texel(input logic [IW-1:0] r, input logic [IW-1:0] c,
                              input logic [IW-1:0] w);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 17) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_radius <= r;
        i_col    <= c;
        i_row    <= w;
        do @(posedge i_clk); while (o_stall);
        pending_texels.push_back(coverage_texel(r, c, w));
    endtask

    // drop valid and let every predicted beat come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_texels.size() != 0)
            @(posedge i_clk);
        repeat (NSTG + 2) @(posedge i_clk);
    endtask

    // random radius in range with col and row inside its block
    task automatic send_in_block();
        logic [IW-1:0] r;
        r = IW'($urandom_range(MIN_RADIUS, MAX_RADIUS));
        send_texel(r, IW'($urandom_range(0, r - 1)), IW'($urandom_range(0, r - 1)));
    endtask

    // corners of the field ranges, block edges, and each out-of-range cause
    task automatic test_directed();
        send_texel(0, 0, 0);
        send_texel(31, 31, 31);
        send_texel(IW'(MIN_RADIUS - 1), 0, 0);                     // radius just below
        send_texel(IW'(MIN_RADIUS), 0, 0);                         // outer corner, least cover
        send_texel(IW'(MIN_RADIUS), IW'(MIN_RADIUS - 1),
                   IW'(MIN_RADIUS - 1));                           // inner corner, full cover
        send_texel(IW'(MIN_RADIUS), IW'(MIN_RADIUS - 1), 0);
        send_texel(IW'(MIN_RADIUS), 0, IW'(MIN_RADIUS - 1));
        send_texel(IW'(MIN_RADIUS), IW'(MIN_RADIUS), 0);           // col equals radius
        send_texel(IW'(MIN_RADIUS), 0, IW'(MIN_RADIUS));           // row equals radius
        send_texel(IW'(MAX_RADIUS), 0, 0);
        send_texel(IW'(MAX_RADIUS), IW'(MAX_RADIUS - 1),
                   IW'(MAX_RADIUS - 1));                           // last texel of the atlas
        send_texel(IW'(MAX_RADIUS), 0, IW'(MAX_RADIUS - 1));
        send_texel(IW'(MAX_RADIUS), IW'(MAX_RADIUS - 1), 0);
        send_texel(IW'(MAX_RADIUS), 31, 0);
        send_texel(IW'(MAX_RADIUS), 0, 31);
        send_texel(IW'(MAX_RADIUS + 1), 0, 0);                     // radius just above
        send_texel(31, 0, 0);
        send_texel(16, 15, 15);
        send_texel(16, 4, 4);                                      // on the disc edge
        send_texel(16, 0, 15);
        send_texel(21, 10, 21);
        send_texel(8, 5, 2);
    endtask

    // well-formed texels only; idle behavior changes every 40 beats
    task automatic test_random_texels();
        for (int blk = 0; blk < 12; blk++) begin
            sender_gaps_on     = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (40) send_in_block();
        end
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // raw random fields, most of them out of range
    task automatic test_random_noise();
        repeat (120) send_texel(IW'($urandom), IW'($urandom), IW'($urandom));
    endtask

    // no idling on either side: one beat per clock end to end
    task automatic test_back_to_back();
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        repeat (60) send_in_block();
        receiver_stalls_on = 1'b1;
    endtask

    // sender never idles while the receiver stalls, so the pipeline fills and o_stall rises
    task automatic test_pipeline_fill();
        sender_gaps_on = 1'b0;
        repeat (40) begin
            if ($urandom_range(0, 1))
                send_in_block();
            else
                send_texel(IW'($urandom), IW'($urandom), IW'($urandom));
        end
        sender_gaps_on = 1'b1;
    endtask

    // stop sending until every beat is out, then restart into an empty pipeline
    task automatic test_drain_pause();
        repeat (20) send_in_block();
        wait_drained();
        repeat (20) send_in_block();
    endtask

    // receiver: a random stall before each output beat when stalls are on, then take it
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            repeat (receiver_stalls_on ? $urandom_range(0, 17) : 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // output check: every accepted beat against the oldest prediction
    always @(posedge i_clk) begin
        t_texel_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_texels.size() == 0) begin
                report_mismatch("output beat with nothing predicted");
            end else begin
                want = pending_texels.pop_front();
                if (o_alpha !== want.alpha)
                    report_mismatch($sformatf("alpha %0d, predicted %0d",
                                              o_alpha, want.alpha));
                if (o_atlas_x !== want.atlas_x)
                    report_mismatch($sformatf("atlas_x %0d, predicted %0d",
                                              o_atlas_x, want.atlas_x));
                if (o_atlas_y !== want.atlas_y)
                    report_mismatch($sformatf("atlas_y %0d, predicted %0d",
                                              o_atlas_y, want.atlas_y));
                if (o_in_range !== want.in_range)
                    report_mismatch($sformatf("in_range %0d, predicted %0d",
                                              o_in_range, want.in_range));
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_radius           = '0;
        i_col              = '0;
        i_row              = '0;
        mismatch_count     = 0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_texels();
        test_random_noise();
        test_back_to_back();
        test_pipeline_fill();
        test_drain_pause();

        // anything still predicted must come out; the run limit catches a hang
        wait_drained();
        if (pending_texels.size() != 0)
            report_mismatch($sformatf("%0d predicted beats never came out",
                                      pending_texels.size()));
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
